FILE: sv/salc_pkg.sv
package salc_pkg;

    // Geometry of the tag store
    localparam int ADDR_BITS  = 48;
    localparam int NUM_SETS   = 2048;
    localparam int SET_BITS   = $clog2(NUM_SETS);
    localparam int NUM_WAYS   = 16;
    localparam int WAY_BITS   = $clog2(NUM_WAYS);
    localparam int BLOCK_BITS = 6;
    localparam int TAG_BITS   = ADDR_BITS - BLOCK_BITS - SET_BITS;

    // Saturating hit / miss totals
    localparam int CNT_BITS = 40;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    // One row per set: all tags, plus valid bits and recency ranks
    typedef logic [NUM_WAYS-1:0][TAG_BITS-1:0] t_tag_row;
    typedef logic [NUM_WAYS-1:0][WAY_BITS-1:0] t_ages;
    typedef logic [NUM_WAYS-1:0]               t_valid;

    typedef struct packed {
        t_valid valid;
        t_ages  ages;
    } t_meta_row;

endpackage

FILE: sv/set_assoc_lru_cache_tags.sv
// Tag store of a 2048-set, 16-way cache with true LRU replacement.
// Input channel: i_valid / o_ready carry one byte address per beat.
// Output channel: o_valid / i_ready carry one result per beat: hit flag,
// the address echoed back, and saturating hit and miss totals that
// include this access.
// Pipeline: the set's row is read into the lookup registers at the accepting
// edge; the lookup stage then compares, updates recency and writes the row
// back as the result enters the output register, once that register is free.
// Throughput: one access per cycle while the receiver takes results.
// The set row read and its write-back form a one-entry read-modify-write
// loop; an access to the same set, accepted as the one before it finishes,
// takes the written-back row from a forwarding register instead of the memory.
// Reset: a clearing pass writes every set's valid bits and ranks to zero,
// one set per cycle, through all 2048 sets; o_ready stays low until it ends. The
// tag memory is not cleared: tags are only compared in valid ways.
// Receiver stall: one result waits in the output register and one access
// waits in the lookup stage; after that o_ready drops until a result
// is taken.
module set_assoc_lru_cache_tags
    import salc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [ADDR_BITS-1:0] i_address,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic [ADDR_BITS-1:0] o_access_address,
    output logic [CNT_BITS-1:0]  o_hit_total,
    output logic [CNT_BITS-1:0]  o_miss_total
);

    // Memories: one row per set
    t_meta_row mem_meta [NUM_SETS];
    t_tag_row  mem_tags [NUM_SETS];

    // Control and pipeline registers
    logic                 r_clearing;
    logic [SET_BITS-1:0]  r_clr_idx;
    logic                 r_busy;
    logic                 r_fwd;
    logic [ADDR_BITS-1:0] r_addr;
    logic [SET_BITS-1:0]  r_set;
    t_meta_row            r_meta_q;
    t_tag_row             r_tags_q;
    t_meta_row            r_wb_meta;
    t_tag_row             r_wb_tags;
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [CNT_BITS-1:0]  r_hits;
    logic [CNT_BITS-1:0]  r_misses;

    // Lookup stage signals
    logic                 accept;
    logic                 done;
    logic [SET_BITS-1:0]  in_set;
    logic [TAG_BITS-1:0]  cur_tag;
    t_valid               cur_valid;
    t_ages                cur_ages;
    t_tag_row             cur_tags;
    t_valid               hit_vec;
    logic                 hit;
    logic [WAY_BITS-1:0]  hit_way;
    logic [WAY_BITS-1:0]  free_way;
    logic [WAY_BITS-1:0]  lru_way;
    logic [WAY_BITS:0]    count;
    logic                 full;
    logic [WAY_BITS-1:0]  way;
    logic [WAY_BITS-1:0]  rank;
    t_valid               n_valid;
    t_ages                n_ages;
    t_tag_row             n_tags;
    logic [CNT_BITS-1:0]  n_hits;
    logic [CNT_BITS-1:0]  n_misses;

    // Handshake
    assign done    = r_busy && (!r_out_valid || i_ready);
    assign o_ready = !r_clearing && (!r_busy || done);
    assign accept  = i_valid && o_ready;
    assign in_set  = i_address[BLOCK_BITS +: SET_BITS];

    // Row of the set under lookup, forwarded on back-to-back same set
    assign cur_tag   = r_addr[ADDR_BITS-1 -: TAG_BITS];
    assign cur_valid = r_fwd ? r_wb_meta.valid : r_meta_q.valid;
    assign cur_ages  = r_fwd ? r_wb_meta.ages  : r_meta_q.ages;
    assign cur_tags  = r_fwd ? r_wb_tags       : r_tags_q;

    // Tag compare, fill count and victim candidates
    always_comb begin
        hit_vec  = '0;
        hit_way  = '0;
        free_way = '0;
        lru_way  = '0;
        count    = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            hit_vec[i] = cur_valid[i] && (cur_tags[i] == cur_tag);
            count      = count + (WAY_BITS + 1)'(cur_valid[i]);
        end
        // walk downward so the lowest matching way wins
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_way = WAY_BITS'(i);
            end
            if (!cur_valid[i]) begin
                free_way = WAY_BITS'(i);
            end
            if (cur_ages[i] == WAY_BITS'(NUM_WAYS - 1)) begin
                lru_way = WAY_BITS'(i);
            end
        end
    end

    assign hit  = |hit_vec;
    assign full = &cur_valid;

    // Chosen way and the rank it leaves
    always_comb begin
        priority if (hit) begin
            way  = hit_way;
            rank = cur_ages[hit_way];
        end else if (full) begin
            way  = lru_way;
            rank = WAY_BITS'(NUM_WAYS - 1);
        end else begin
            way  = free_way;
            rank = count[WAY_BITS-1:0];
        end
    end

    // Recency update and row write-back data
    always_comb begin
        n_valid      = cur_valid;
        n_valid[way] = 1'b1;
        n_tags       = cur_tags;
        if (!hit) begin
            n_tags[way] = cur_tag;
        end
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (cur_valid[i] && (WAY_BITS'(i) != way) && (cur_ages[i] < rank)) begin
                n_ages[i] = cur_ages[i] + 1'b1;
            end else begin
                n_ages[i] = cur_ages[i];
            end
        end
        n_ages[way] = '0;
    end

    // Saturating totals
    assign n_hits   = (hit && (r_hits != CNT_MAX)) ? r_hits + 1'b1 : r_hits;
    assign n_misses = (!hit && (r_misses != CNT_MAX)) ? r_misses + 1'b1 : r_misses;

    // Memory ports: clearing pass or write-back, read on accept
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem_meta[r_clr_idx] <= '0;
        end else if (done) begin
            mem_meta[r_set] <= '{valid: n_valid, ages: n_ages};
        end
        if (accept) begin
            r_meta_q <= mem_meta[in_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            mem_tags[r_set] <= n_tags;
        end
        if (accept) begin
            r_tags_q <= mem_tags[in_set];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_address;
            r_set  <= in_set;
        end
        if (done) begin
            r_wb_meta  <= '{valid: n_valid, ages: n_ages};
            r_wb_tags  <= n_tags;
            r_out_hit  <= hit;
            r_out_addr <= r_addr;
        end
    end

    // Control registers and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_busy      <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == SET_BITS'(NUM_SETS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_fwd  <= done && (in_set == r_set);
            end else if (done) begin
                r_busy <= 1'b0;
                r_fwd  <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
                r_hits      <= n_hits;
                r_misses    <= n_misses;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Totals change only with a new result, so they drive the ports directly
    assign o_valid          = r_out_valid;
    assign o_hit            = r_out_hit;
    assign o_access_address = r_out_addr;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;

    // Forwarding only ever applies to an access in the lookup stage
    a_fwd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_busy)
        else $error("forwarding flag set with no access in lookup");

    // Nothing is in flight during the clearing pass
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_busy && !r_out_valid))
        else $error("access in flight during clearing pass");

    // A tag is present at most once in a set
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(hit_vec))
        else $error("tag matched in more than one way");

    // Each finished access bumps exactly one unsaturated total
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && hit && (r_hits != CNT_MAX)) |=>
            ((r_hits == $past(r_hits) + 1'b1) && (r_misses == $past(r_misses))))
        else $error("hit total not advanced by one");

    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !hit && (r_misses != CNT_MAX)) |=>
            ((r_misses == $past(r_misses) + 1'b1) && (r_hits == $past(r_hits))))
        else $error("miss total not advanced by one");

endmodule
